// File: design/lvd_pkg.sv
// shared constants, types and state codes for the edit distance block
package lvd_pkg;

    localparam int MAX_QUERY_LEN  = 8;
    localparam int MAX_TARGET_LEN = 255;

    // widths of the row entries, query length and row index
    localparam int CHAR_W  = 8;
    localparam int DIST_W  = 8;
    localparam int QLEN_W  = 4;
    localparam int QUERY_W = MAX_QUERY_LEN * CHAR_W;
    localparam int ROW_IDX_W = $clog2(MAX_QUERY_LEN + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_CHARS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_LENGTH = 1'b1;

    localparam logic [DIST_W-1:0] DIST_SAT      = {DIST_W{1'b1}};
    localparam logic [DIST_W-1:0] TARGET_LIMIT  = DIST_W'(MAX_TARGET_LEN);

    // data handed from one cell to the next
    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] ch;
        logic [DIST_W-1:0] cur;
        logic [DIST_W-1:0] diag;
    } lvd_link_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } lvd_state_t;

endpackage

// File: design/levenshtein_distance.sv
// top level: query registers, row count, cell chain and result register
//
// Edit distance between a query of up to eight bytes, written through the
// configuration port, and a target string streamed one byte per transfer.
// Slave side: s_tdata carries the target byte, s_tuser says the byte is real
// (0 for an empty end marker), s_tlast ends the target. One result transfer
// leaves on the master side for each input with s_tlast set.
// A real byte, while the row count is below 255, launches a wave down a
// chain of eight column cells, one cell per cycle; the block takes the next
// transfer once the wave has left the last cell. A transfer that launches
// no wave goes from idle straight to the finish state. A result is loaded
// into the result register in the finish state of its closing transfer,
// once the result register is free.
// The result register holds until taken; the block keeps accepting input
// meanwhile and only waits, before forming the next result, while the
// receiver has not yet taken the previous one.
// Reset clears the row to its initial values, the count, the overflow mark,
// the query registers and the result register.
module levenshtein_distance
    import lvd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [QUERY_W-1:0]   cfg_data,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] target_char
    input  logic [0:0]           s_tuser,   // [0] char_present
    input  logic                 s_tlast,   // last_char
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] distance
    output logic [1:0]           m_tuser    // [0] close_match, [1] too_long
);

    logic [QUERY_W-1:0] query_chars_reg;
    logic [QLEN_W-1:0]  query_length_reg;
    lvd_state_t         state_reg;
    lvd_state_t         state_next;
    logic               last_pend_reg;
    logic [DIST_W-1:0]  rows_done_reg;
    logic               overflow_reg;
    lvd_link_t          launch_reg;
    logic               m_valid_reg;
    logic [DIST_W-1:0]  m_dist_reg;
    logic               m_close_reg;
    logic               m_long_reg;

    lvd_link_t          links [0:MAX_QUERY_LEN];
    logic [DIST_W-1:0]  row_vals [0:MAX_QUERY_LEN];

    logic               accept;
    logic               launch;
    logic               wave_done;
    logic               out_free;
    logic               emit;
    logic [ROW_IDX_W-1:0] qlen;
    logic [DIST_W-1:0]  row_pick;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_chars_reg  <= '0;
            query_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_QUERY_CHARS:  query_chars_reg  <= cfg_data;
                REG_QUERY_LENGTH: query_length_reg <= cfg_data[QLEN_W-1:0];
                default:          query_chars_reg  <= query_chars_reg;
            endcase
        end
    end

    // handshake and control decode
    assign accept    = s_tvalid && s_tready;
    assign launch    = accept && s_tuser[0] && (rows_done_reg < TARGET_LIMIT);
    assign wave_done = links[MAX_QUERY_LEN].valid;
    assign out_free  = !m_valid_reg || m_tready;

    // sequencer: launch, wait for the wave, then finish the item
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        emit       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    state_next = launch ? ST_RUN : ST_FINISH;
                end
            end
            ST_RUN:
            begin
                if (wave_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!last_pend_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // row count, overflow mark and pending end flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_done_reg <= '0;
            overflow_reg  <= 1'b0;
            last_pend_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                last_pend_reg <= s_tlast;
            end
            if (emit)
            begin
                rows_done_reg <= '0;
                overflow_reg  <= 1'b0;
            end
            else if (launch)
            begin
                rows_done_reg <= rows_done_reg + {{(DIST_W-1){1'b0}}, 1'b1};
            end
            else if (accept && s_tuser[0])
            begin
                overflow_reg <= 1'b1;
            end
        end
    end

    // wave launch into the first cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_reg <= '0;
        end
        else
        begin
            launch_reg.valid <= launch;
            if (launch)
            begin
                launch_reg.ch   <= s_tdata;
                launch_reg.cur  <= rows_done_reg + {{(DIST_W-1){1'b0}}, 1'b1};
                launch_reg.diag <= rows_done_reg;
            end
        end
    end

    assign links[0]    = launch_reg;
    assign row_vals[0] = rows_done_reg;

    // chain of column cells
    for (genvar j = 1; j <= MAX_QUERY_LEN; j++)
    begin : g_cell
        lvd_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .link_in    (links[j-1]),
            .query_char (query_chars_reg[CHAR_W*(j-1) +: CHAR_W]),
            .init_value (DIST_W'(j)),
            .clear      (emit),
            .link_out   (links[j]),
            .value      (row_vals[j])
        );
    end

    // result column select
    always_comb
    begin
        if (query_length_reg > QLEN_W'(MAX_QUERY_LEN))
        begin
            qlen = ROW_IDX_W'(MAX_QUERY_LEN);
        end
        else
        begin
            qlen = query_length_reg[ROW_IDX_W-1:0];
        end
        row_pick = row_vals[qlen];
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            m_dist_reg  <= '0;
            m_close_reg <= 1'b0;
            m_long_reg  <= 1'b0;
        end
        else if (emit)
        begin
            m_valid_reg <= 1'b1;
            if (overflow_reg)
            begin
                m_dist_reg  <= DIST_SAT;
                m_close_reg <= 1'b0;
                m_long_reg  <= 1'b1;
            end
            else
            begin
                m_dist_reg  <= row_pick;
                m_close_reg <= (row_pick <= {{(DIST_W-1){1'b0}}, 1'b1});
                m_long_reg  <= 1'b0;
            end
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_dist_reg;
    assign m_tuser  = {m_long_reg, m_close_reg};

endmodule

// File: design/lvd_cell.sv
// one column of the distance row: holds its entry and passes the wave on
module lvd_cell
    import lvd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lvd_link_t         link_in,
    input  logic [CHAR_W-1:0] query_char,
    input  logic [DIST_W-1:0] init_value,
    input  logic              clear,
    output lvd_link_t         link_out,
    output logic [DIST_W-1:0] value
);

    logic [DIST_W-1:0] value_reg;
    lvd_link_t         link_reg;
    logic [DIST_W-1:0] min_a;
    logic [DIST_W-1:0] min_b;
    logic [DIST_W:0]   sum;
    logic [DIST_W-1:0] cur_next;

    // match takes the diagonal, otherwise one plus the smallest neighbor, saturating
    always_comb
    begin
        min_a    = (link_in.cur < value_reg) ? link_in.cur : value_reg;
        min_b    = (link_in.diag < min_a) ? link_in.diag : min_a;
        sum      = {1'b0, min_b} + {{DIST_W{1'b0}}, 1'b1};
        if (link_in.ch == query_char)
        begin
            cur_next = link_in.diag;
        end
        else if (sum[DIST_W])
        begin
            cur_next = DIST_SAT;
        end
        else
        begin
            cur_next = sum[DIST_W-1:0];
        end
    end

    // row entry and link register toward the next column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= init_value;
            link_reg  <= '0;
        end
        else
        begin
            link_reg.valid <= link_in.valid;
            if (link_in.valid)
            begin
                value_reg     <= cur_next;
                link_reg.ch   <= link_in.ch;
                link_reg.cur  <= cur_next;
                link_reg.diag <= value_reg;
            end
            if (clear)
            begin
                value_reg <= init_value;
            end
        end
    end

    assign link_out = link_reg;
    assign value    = value_reg;

endmodule
